[rtl/clsc_pkg.sv]
// Shared types, op codes and sizing constants for the compacting list store.
package clsc_pkg;

    // Default sizing of the list.
    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_ITEM_WIDTH = 32;

    // Field widths on the streaming ports.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // Packed tdata widths, rounded up to whole bytes.
    localparam int IN_BITS   = OP_W + INDEX_W + VALUE_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = VALUE_W + STATUS_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Cells per first-level group of the read-back OR tree.
    localparam int READ_GROUP = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND      = 3'd0,
        OP_REMOVE_AT   = 3'd1,
        OP_READ_HEAD   = 3'd2,
        OP_READ_TAIL   = 3'd3,
        OP_REMOVE_TAIL = 3'd4,
        OP_CLEAR       = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic app;   // load the append value into the cell at the position
        logic rem;   // cells at or above the position take their neighbor
        logic rd;    // the cell at the position drives its entry on the tap
    } t_cell_ctrl;

endpackage

[rtl/clsc_cell.sv]
// One storage cell of the compacting list: holds an entry, loads or shifts down.
module clsc_cell #(
    parameter int ITEM_WIDTH = clsc_pkg::DEF_ITEM_WIDTH,
    parameter int POS_W      = 7,
    parameter int POS        = 0
) (
    input  logic                  i_clk,
    input  clsc_pkg::t_cell_ctrl  i_ctrl,
    input  logic [POS_W-1:0]      i_pos,
    input  logic [ITEM_WIDTH-1:0] i_item,
    input  logic [ITEM_WIDTH-1:0] i_next,
    output logic [ITEM_WIDTH-1:0] o_item,
    output logic [ITEM_WIDTH-1:0] o_tap
);
    import clsc_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [ITEM_WIDTH-1:0] r_item;
    logic [ITEM_WIDTH-1:0] n_item;

    always_comb begin
        n_item = r_item;
        priority if (i_ctrl.app && (i_pos == MY_POS)) begin
            n_item = i_item;
        end else if (i_ctrl.rem && (MY_POS >= i_pos)) begin
            n_item = i_next;
        end else begin
            // hold the entry
            n_item = r_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;
    assign o_tap  = (i_ctrl.rd && (i_pos == MY_POS)) ? r_item : '0;

endmodule

[rtl/compacting_list_store_core.sv]
// Top level of the compacting list store: cell chain, request decode, result pipe.
//
// Usage: requests arrive on the slave stream (i_s_*), one transaction per
// request; each request yields exactly one result transaction on the master
// stream (o_m_*). The list lives in a row of CAPACITY cells, cell 0 at the
// head. An append loads the cell just past the tail; a remove-at-index makes
// every cell at or above the index take its upper neighbor in the same cycle,
// so every request is finished in the cycle it is accepted.
// Throughput: one request per cycle while the receiver takes results. A result
// is registered in the middle stage and then in the output register; the
// read-back of the addressed cell runs through a two-level OR tree (groups of
// READ_GROUP cells, then the groups) with a register after each level.
// Reset (synchronous, active low) empties the list and drops any result in
// flight; cell contents are not cleared and are never read before written.
// When the receiver stalls, the finished result holds on o_m_*, one more
// request is still taken into the middle stage if it is empty, then o_s_tready
// drops until the output moves again.
module compacting_list_store_core #(
    parameter int CAPACITY   = clsc_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = clsc_pkg::DEF_ITEM_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [2:0] op, [9:3] index, [41:10] item_value, upper bits zero
    input  logic [clsc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [31:0] read_value, [33:32] status, [41:34] entry_count, upper bits zero
    output logic [clsc_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import clsc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int NUM_GRP = (CAPACITY + READ_GROUP - 1) / READ_GROUP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // ---- request fields ----
    t_op                   w_op;
    logic [INDEX_W-1:0]    w_index;
    logic [VALUE_W-1:0]    w_value;
    logic [ITEM_WIDTH+VALUE_W-1:0] w_value_wide;
    logic [ITEM_WIDTH-1:0] w_item;

    assign w_op    = t_op'(i_s_tdata[OP_W-1:0]);
    assign w_index = i_s_tdata[OP_W +: INDEX_W];
    assign w_value = i_s_tdata[OP_W+INDEX_W +: VALUE_W];
    // Keep the low ITEM_WIDTH bits; zero-fill when cells are wider than the field.
    assign w_value_wide = {{ITEM_WIDTH{1'b0}}, w_value};
    assign w_item       = w_value_wide[ITEM_WIDTH-1:0];

    // ---- control registers ----
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_s1_valid;
    logic             r_o_valid;

    logic w_s2_en;
    logic w_accept;

    // Advance the output stage when it is empty or being taken; the middle
    // stage may load whenever it is empty or moving on.
    assign w_s2_en    = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_s2_en;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // ---- decode ----
    logic [CMP_W-1:0] w_idx_c;
    logic [CMP_W-1:0] w_cnt_c;
    logic [CMP_W-1:0] w_tail_c;
    logic             w_in_range;
    logic             w_full;
    logic [POS_W-1:0] w_pos;
    t_cell_ctrl       w_ctrl;
    t_status          w_status;

    assign w_idx_c    = CMP_W'(w_index);
    assign w_cnt_c    = CMP_W'(r_count);
    assign w_tail_c   = w_cnt_c - CMP_W'(1) - w_idx_c;
    assign w_in_range = w_idx_c < w_cnt_c;
    assign w_full     = (r_count == CAP_CNT);

    always_comb begin
        w_pos    = w_idx_c[POS_W-1:0];
        w_ctrl   = '0;
        w_status = ST_OK;
        n_count  = r_count;
        unique case (w_op)
            OP_APPEND: begin
                w_pos = r_count[POS_W-1:0];
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.app = w_accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rem = w_accept;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            OP_READ_HEAD: begin
                w_ctrl.rd = w_in_range;
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end
            end
            OP_READ_TAIL: begin
                w_pos     = w_tail_c[POS_W-1:0];
                w_ctrl.rd = w_in_range;
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end
            end
            OP_REMOVE_TAIL: begin
                if (r_count == '0) begin
                    w_status = ST_RANGE;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // Unused op codes: leave the list alone.
            end
        endcase
    end

    // ---- cell chain ----
    logic [ITEM_WIDTH-1:0] w_cell [CAPACITY];
    logic [ITEM_WIDTH-1:0] w_tap  [CAPACITY];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_next;
        // The top cell has no upper neighbor; its shifted value is beyond the tail.
        if (gi == CAPACITY - 1) begin : g_top
            assign w_next = w_cell[gi];
        end else begin : g_mid
            assign w_next = w_cell[gi+1];
        end
        clsc_cell #(
            .ITEM_WIDTH(ITEM_WIDTH),
            .POS_W     (POS_W),
            .POS       (gi)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctrl(w_ctrl),
            .i_pos (w_pos),
            .i_item(w_item),
            .i_next(w_next),
            .o_item(w_cell[gi]),
            .o_tap (w_tap[gi])
        );
    end

    // ---- read-back tree, first level ----
    logic [ITEM_WIDTH-1:0] w_grp  [NUM_GRP];
    logic [ITEM_WIDTH-1:0] r_s1_grp [NUM_GRP];
    t_status               r_s1_status;
    logic [COUNT_W-1:0]    r_s1_count;
    logic [CNT_W+COUNT_W-1:0] w_count_wide;

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < READ_GROUP; k++) begin
                if (g * READ_GROUP + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_tap[g * READ_GROUP + k];
                end
            end
        end
    end

    // Report the low byte of the count after this request.
    assign w_count_wide = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (o_s_tready) begin
                r_s1_valid <= w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_grp    <= w_grp;
            r_s1_status <= w_status;
            r_s1_count  <= w_count_wide[COUNT_W-1:0];
        end
    end

    // ---- read-back tree, second level and output register ----
    logic [ITEM_WIDTH-1:0]         w_rd_item;
    logic [ITEM_WIDTH+VALUE_W-1:0] w_rd_wide;
    logic [OUT_DATA_W-1:0]         r_o_data;

    always_comb begin
        w_rd_item = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            w_rd_item = w_rd_item | r_s1_grp[g];
        end
    end

    assign w_rd_wide = {{VALUE_W{1'b0}}, w_rd_item};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_en) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_valid) begin
            r_o_data <= OUT_DATA_W'({r_s1_count, r_s1_status, w_rd_wide[VALUE_W-1:0]});
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries behind");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_status == ST_FULL)) |-> (r_count == CAP_CNT))
        else $error("full status reported on a list that is not full");

    // The pending result carries the count of the list as it stands now,
    // unless a newer request is being taken in this very cycle.
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_count == COUNT_W'(r_count) || w_accept))
        else $error("pending result count differs from list count");

    a_no_double_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.app && w_ctrl.rem) && !((w_ctrl.app || w_ctrl.rem) && !w_accept))
        else $error("cell command issued without a single accepted request");

endmodule

[test/compacting_list_store_core_tb.sv]
// Self-checking testbench for the compacting list store core.
module compacting_list_store_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clsc_pkg::*;

    localparam int LIST_CAPACITY = DEF_CAPACITY;
    localparam int ITEM_BITS     = DEF_ITEM_WIDTH;

    // Op codes that the block decodes as no-ops.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Receiver behaviors, switched at random intervals.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_MOSTLY   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    localparam int HOLDOFF_CYCLES = 80;    // long receiver stall for the backpressure test
    localparam int QUIET_LIMIT    = 4000;  // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES   = 8;     // margin for late extras after the result pipe drains

    typedef struct {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_list_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // [2:0] op, [9:3] index, [41:10] item_value
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [31:0] read_value, [33:32] status,
                                              // [41:34] entry_count

    // Shadow copy of the list, advanced once per accepted request.
    logic [ITEM_BITS-1:0] list_cells [LIST_CAPACITY];
    int                   shadow_count = 0;

    t_list_result pending_results [$];
    int           error_count = 0;
    int           quiet_cycles = 0;

    // Sender burst state.
    int burst_left = 0;

    // Receiver state; the test side bumps holdoff_requests to ask for a long stall.
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;
    int rx_mode          = RX_ALWAYS;
    int rx_mode_left     = 0;
    int rx_phase         = 0;

    compacting_list_store_core #(
        .CAPACITY   (LIST_CAPACITY),
        .ITEM_WIDTH (ITEM_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the result it must produce.
    function automatic t_list_result next_list_result(input logic [OP_W-1:0] op,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic [VALUE_W-1:0] value);
        t_list_result res;
        int           pos;
        res.read_value = '0;
        res.status     = ST_OK;
        case (op)
            OP_APPEND: begin
                if (shadow_count >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_cells[shadow_count] = value[ITEM_BITS-1:0];
                    shadow_count++;
                end
            end
            OP_REMOVE_AT: begin
                if (int'(idx) >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    // every later entry moves down one cell
                    for (pos = int'(idx); pos + 1 < shadow_count; pos++)
                        list_cells[pos] = list_cells[pos + 1];
                    shadow_count--;
                end
            end
            OP_READ_HEAD: begin
                if (int'(idx) >= shadow_count)
                    res.status = ST_RANGE;
                else
                    res.read_value = VALUE_W'(list_cells[idx]);
            end
            OP_READ_TAIL: begin
                if (int'(idx) >= shadow_count)
                    res.status = ST_RANGE;
                else
                    res.read_value = VALUE_W'(list_cells[shadow_count - 1 - int'(idx)]);
            end
            OP_REMOVE_TAIL: begin
                if (shadow_count == 0)
                    res.status = ST_RANGE;
                else
                    shadow_count--;
            end
            OP_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
        res.entry_count = COUNT_W'(shadow_count);
        return res;
    endfunction

    // Offer one request, hold it until the block takes it, then record the
    // expected result. Between bursts, sometimes drop tvalid for a random gap.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] value);
        logic [IN_DATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[OP_W-1:0]                 = op;
        word[OP_W +: INDEX_W]          = idx;
        word[OP_W + INDEX_W +: VALUE_W] = value;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(next_list_result(op, idx, value));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Compare one result transaction with the oldest expectation, field by field.
    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        t_list_result          want;
        logic [VALUE_W-1:0]    got_value;
        logic [STATUS_W-1:0]   got_status;
        logic [COUNT_W-1:0]    got_count;
        logic [OUT_DATA_W-1:0] got_pad;
        got_value  = word[VALUE_W-1:0];
        got_status = word[VALUE_W +: STATUS_W];
        got_count  = word[VALUE_W + STATUS_W +: COUNT_W];
        got_pad    = word >> OUT_BITS;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual tdata %h", $time, word);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value, got_value);
            error_count++;
        end
        if (got_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            error_count++;
        end
        if (got_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, got_count);
            error_count++;
        end
        if (got_pad !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time, got_pad);
            error_count++;
        end
    endtask

    // Check every accepted result and track how long the bus has been quiet.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (o_m_tvalid && i_m_tready)
                check_result(o_m_tdata);
        end
    end

    // Receiver: a long hold-off when asked, otherwise a stall pattern that
    // changes at random intervals.
    always @(posedge i_clk) begin
        if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                rx_mode_left = $urandom_range(16, 200);
            end else begin
                rx_mode_left--;
            end
            rx_phase = (rx_phase + 1) % 3;
            case (rx_mode)
                RX_ALWAYS: i_m_tready <= 1'b1;
                RX_MOSTLY: i_m_tready <= ($urandom_range(0, 4) != 0);
                RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_tready <= (rx_phase != 0);
            endcase
        end
    end

    // Watchdog: no transaction on either side for too long ends the run.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL compacting_list_store_core");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Mostly a valid position in the current list, sometimes anything.
    function automatic logic [INDEX_W-1:0] pick_index();
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            return INDEX_W'($urandom_range(0, shadow_count - 1));
        return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    endfunction

    // Op for a loose mix of reads and writes, keyed off a running count.
    function automatic logic [OP_W-1:0] OP_e_pick(input int n);
        case (n % 4)
            0: return OP_APPEND;
            1: return OP_READ_HEAD;
            2: return OP_READ_TAIL;
            default: return OP_REMOVE_AT;
        endcase
    endfunction

    // Every op but append against an empty list, plus the unused codes.
    task automatic test_empty_list();
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_REMOVE_TAIL, '0, '0);
        send_request(OP_REMOVE_AT, '0, '0);
        send_request(OP_READ_HEAD, '0, '0);
        send_request(OP_READ_TAIL, '1, '0);
        send_request(OP_UNUSED_LO, '1, '1);
        send_request(OP_UNUSED_HI, '0, 32'hA5A5_5A5A);
    endtask

    // Small list: value extremes, reads from both ends, shift on remove, clear.
    task automatic test_basic_ops();
        send_request(OP_APPEND, '0, '0);
        send_request(OP_APPEND, '1, '1);
        send_request(OP_APPEND, '0, 32'hA5A5_A5A5);
        send_request(OP_APPEND, '0, 32'h5A5A_5A5A);
        send_request(OP_READ_HEAD, 7'd0, '0);
        send_request(OP_READ_TAIL, 7'd0, '0);
        send_request(OP_READ_HEAD, 7'd3, '0);
        send_request(OP_READ_HEAD, 7'd4, '0);     // one past the tail
        send_request(OP_READ_TAIL, '1, '0);
        send_request(OP_REMOVE_AT, 7'd1, '0);     // middle entry, tail shifts down
        send_request(OP_READ_HEAD, 7'd1, '0);
        send_request(OP_REMOVE_AT, 7'd2, '0);     // last entry
        send_request(OP_REMOVE_AT, 7'd2, '0);     // now out of range
        send_request(OP_REMOVE_TAIL, '0, '0);
        send_request(OP_READ_TAIL, 7'd0, '0);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_READ_HEAD, 7'd0, '0);
    endtask

    // Fill every cell, bounce off the full list, then shift the whole chain.
    task automatic test_fill_to_capacity();
        int n;
        send_request(OP_CLEAR, '0, '0);
        for (n = 0; n < LIST_CAPACITY; n++)
            send_request(OP_APPEND, pick_index(), pick_value());
        send_request(OP_APPEND, '0, '1);
        send_request(OP_APPEND, '1, '0);
        send_request(OP_READ_HEAD, '1, '0);
        send_request(OP_READ_TAIL, '1, '0);
        send_request(OP_REMOVE_AT, 7'd0, '0);
        send_request(OP_READ_HEAD, 7'd0, '0);
        send_request(OP_READ_TAIL, 7'd0, '0);
        send_request(OP_APPEND, '0, pick_value());
        send_request(OP_REMOVE_AT, '1, '0);
        send_request(OP_READ_HEAD, 7'd126, '0);
        send_request(OP_REMOVE_TAIL, '0, '0);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // Stall the receiver for a long stretch while requests keep coming.
    task automatic test_backpressure();
        int n;
        for (n = 0; n < 6; n++)
            send_request(OP_APPEND, '0, pick_value());
        holdoff_requests++;
        for (n = 0; n < 34; n++)
            send_request(OP_e_pick(n), pick_index(), pick_value());
    endtask

    // Long random run in phases that grow, hold or shrink the list.
    task automatic test_random_traffic(input int items);
        int               n;
        int               phase_left;
        int               append_weight;
        int               r;
        logic [OP_W-1:0]  op;
        phase_left    = 0;
        append_weight = 50;
        for (n = 0; n < items; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(60, 300);
                case ($urandom_range(0, 2))
                    0:       append_weight = 70;   // grow
                    1:       append_weight = 40;   // hold
                    default: append_weight = 15;   // shrink
                endcase
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
            end else if (r < 4) begin
                op = OP_CLEAR;
            end else if (r < 4 + append_weight) begin
                op = OP_APPEND;
            end else begin
                case ($urandom_range(0, 3))
                    0:       op = OP_REMOVE_AT;
                    1:       op = OP_READ_HEAD;
                    2:       op = OP_READ_TAIL;
                    default: op = OP_REMOVE_TAIL;
                endcase
            end
            send_request(op, pick_index(), pick_value());
        end
    endtask

    initial begin
        // hold reset at the start, then release it for the rest of the run
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_fill_to_capacity();
        test_backpressure();
        test_random_traffic(1250);

        // stop offering, drain the result pipe, then give late extras a chance
        if (i_s_tvalid)
            i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS compacting_list_store_core");
        else
            $display("FAIL compacting_list_store_core");
        $finish;
    end

endmodule
